// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix multiply checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("imm assertion failed");

// Next-cycle implication, disabled during reset.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("imm assertion failed");

`endif

// ===== rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Types, constants and helpers shared by the integer matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 32;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * DIM_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ACC_W      = 64;
  localparam int CFG_W      = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // input action codes
  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_RUN         = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_FIRST,
    OP_LOAD_SECOND,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [DIM_W-1:0]       row;
    logic [DIM_W-1:0]       col;
    logic [ELEM_WIDTH-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_last;
    logic [DIM_W-1:0] inner_last;
    logic [DIM_W-1:0] cols_last;
  } dims_t;

  typedef struct packed {
    logic             first_k;
    logic             last_k;
    logic             last;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } tag_t;

  // Last index of a dimension register: zero acts as one, above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] dim_val);
    if (dim_val == '0) begin
      dim_last = '0;
    end else if (dim_val > CFG_W'(MAX_DIM)) begin
      dim_last = DIM_W'(MAX_DIM - 1);
    end else begin
      dim_last = DIM_W'(dim_val - 4'd1);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/imm_front.sv =====
// ----------------------------------------------------------------------------
// imm_front
// Accepts input words, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_front import imm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_action,
  input  wire logic [DIM_W-1:0]      in_elem_row,
  input  wire logic [DIM_W-1:0]      in_elem_col,
  input  wire logic [ELEM_WIDTH-1:0] in_elem_value,
  output logic                       q_valid,
  output item_t                      q_head,
  input  wire logic                  q_pop
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              accept;
  logic              known;
  logic              push;
  item_t             item;

  assign busy    = (count_r == QCNT_W'(QDEPTH));
  assign accept  = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    item.row   = in_elem_row;
    item.col   = in_elem_col;
    item.value = in_elem_value;
    item.op    = OP_RUN;
    known      = 1'b1;
    case (in_action)
      ACT_LOAD_FIRST:  item.op = OP_LOAD_FIRST;
      ACT_LOAD_SECOND: item.op = OP_LOAD_SECOND;
      ACT_RUN:         item.op = OP_RUN;
      default:         known = 1'b0;  // drop unknown actions
    endcase
  end

  assign push = accept && known;

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imm_back.sv =====
// ----------------------------------------------------------------------------
// imm_back
// Executes queued words: element loads into the stores, and multiply runs
// through a read, multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_back import imm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire item_t             q_head,
  output logic                   q_pop,
  input  wire dims_t             dims,
  output logic                   out_valid,
  output logic [DIM_W-1:0]       out_row,
  output logic [DIM_W-1:0]       out_col,
  output logic signed [ACC_W-1:0] out_value,
  output logic                   out_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic [DIM_W-1:0]  r_r, r_nxt;
  logic [DIM_W-1:0]  c_r, c_nxt;
  logic              issue;
  tag_t              tag;

  logic              we_first, we_second;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr_first, raddr_second;
  logic [ELEM_WIDTH-1:0] rd_first, rd_second;

  logic              s1_valid_r;
  tag_t              s1_tag_r;
  logic              s2_valid_r;
  tag_t              s2_tag_r;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r;
  logic              out_last_r;
  logic [DIM_W-1:0]  out_row_r, out_col_r;
  logic signed [ACC_W-1:0] out_value_r;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign issue = (state_r == S_RUN);

  assign we_first  = q_pop && (q_head.op == OP_LOAD_FIRST);
  assign we_second = q_pop && (q_head.op == OP_LOAD_SECOND);
  assign waddr     = {q_head.row, q_head.col};

  // second[r][k] and first[k][c]
  assign raddr_second = {r_r, k_r};
  assign raddr_first  = {k_r, c_r};

  imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_first (
    .clk   (clk),
    .we    (we_first),
    .waddr (waddr),
    .wdata (q_head.value),
    .raddr (raddr_first),
    .rdata (rd_first)
  );

  imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_second (
    .clk   (clk),
    .we    (we_second),
    .waddr (waddr),
    .wdata (q_head.value),
    .raddr (raddr_second),
    .rdata (rd_second)
  );

  always_comb begin
    tag.first_k = (k_r == '0);
    tag.last_k  = (k_r == dims.inner_last);
    tag.last    = tag.last_k && (r_r == dims.rows_last) && (c_r == dims.cols_last);
    tag.row     = r_r;
    tag.col     = c_r;
  end

  // Sequencer: k innermost, then row, then column.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop && (q_head.op == OP_RUN)) begin
          k_nxt     = '0;
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tag.last_k) begin
          k_nxt = '0;
          if (r_r == dims.rows_last) begin
            r_nxt = '0;
            if (c_r == dims.cols_last) begin
              c_nxt     = '0;
              state_nxt = S_IDLE;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign prod    = $signed(rd_second) * $signed(rd_first);
  assign acc_nxt = (s2_tag_r.first_k ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_tag_r.last_k;
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= tag;
    s2_tag_r <= s1_tag_r;
    prod_r   <= prod;
    if (s2_valid_r && s2_tag_r.last_k) begin
      out_value_r <= acc_nxt;
      out_row_r   <= s2_tag_r.row;
      out_col_r   <= s2_tag_r.col;
      out_last_r  <= s2_tag_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_valid_r && out_last_r;

endmodule

`default_nettype wire

// ===== rtl/integer_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Signed integer matrix multiplier: product[r][c] = sum_k second[r][k] *
// first[k][c], 64-bit wrapping accumulation, results column by column.
//
//   channel   ports                                   handshake
//   input     in_action, in_elem_row/col/value        start & !busy
//   result    out_row, out_col, out_value, out_last   out_valid strobe
//   config    psel, penable, pwrite, paddr, pwdata    APB, pready always high
//
// A load is written to its store as it is popped; a start is popped, then runs
// rows*cols*inner reads through the read/multiply/accumulate pipeline, one store
// read per cycle, and each result passes the read, product and output registers.
// busy rises when the two-word queue between front and back end is full.
// Reset (rst_n low, synchronous) empties the queue and sets all dimensions
// to 8; the element stores are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_multiply_core import imm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_action,
  input  wire logic [DIM_W-1:0]       in_elem_row,
  input  wire logic [DIM_W-1:0]       in_elem_col,
  input  wire logic [ELEM_WIDTH-1:0]  in_elem_value,
  output logic                        out_valid,
  output logic [DIM_W-1:0]            out_row,
  output logic [DIM_W-1:0]            out_col,
  output logic signed [ACC_W-1:0]     out_value,
  output logic                        out_last,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [CFG_W-1:0] rows_r, inner_r, cols_r;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_rd;
  dims_t            dims;
  logic             q_valid;
  item_t            q_head;
  logic             q_pop;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_RESET;
      inner_r <= DIM_RESET;
      cols_r  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS:  rows_r  <= pwdata[CFG_W-1:0];
        REG_INNER: inner_r <= pwdata[CFG_W-1:0];
        REG_COLS:  cols_r  <= pwdata[CFG_W-1:0];
        default:   ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS:  cfg_rd = rows_r;
      REG_INNER: cfg_rd = inner_r;
      REG_COLS:  cfg_rd = cols_r;
      default:   cfg_rd = '0;
    endcase
  end

  assign prdata = {{(32 - CFG_W){1'b0}}, cfg_rd};

  assign dims.rows_last  = dim_last(rows_r);
  assign dims.inner_last = dim_last(inner_r);
  assign dims.cols_last  = dim_last(cols_r);

  imm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  imm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .dims      (dims),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/imm_checker.sv =====
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks on the matrix multiply core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imm_checker import imm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_last,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // busy is low (queue not full) right after reset
  `IMM_ASSERT_IMP(a_busy_after_reset, clk, rst_n, $past(!rst_n), !busy)

  // a register reads back what was just written to it
  `IMM_ASSERT_IMP(a_cfg_readback, clk, rst_n,
    psel && !pwrite && (paddr == $past(paddr)) && (paddr[3:2] <= REG_COLS) &&
      $past(psel && penable && pwrite && pready),
    prdata[3:0] == $past(pwdata[3:0]))

  // the last word of a run is never followed at once by another result
  `IMM_ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid && out_last, !out_valid)

  // out_last only marks a result word
  `IMM_ASSERT_IMP(a_last_strobe, clk, rst_n, out_last, out_valid)

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);

`default_nettype wire

// ===== tb/integer_matrix_multiply_core_test.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core_test
// Self-checking bench for the matrix multiply core. A short directed table
// covers overflow extremes, ignored actions and unused loads. Random phases
// then follow with varied dimensions, including out-of-range register
// values, and bursty loads and starts. Each product word is checked against the
// table's sum, or in random phases a local model of stores and dimension registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_matrix_multiply_core_test;
  import imm_pkg::*;

  localparam logic [1:0] ACT_NONE      = 2'd3;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         RANDOM_ITEMS  = 300;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        typed;
    logic [63:0] typed_sum;
  } directed_row_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
    logic        last;
  } product_word_t;

  // dimensions are 1x1x1 while this list runs
  localparam int N_DIRECTED = 16;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{ACT_LOAD_SECOND, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 64'h0},
    '{ACT_LOAD_FIRST,  3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 64'h0},
    '{ACT_RUN,         3'd0, 3'd0, 32'h0,         1'b1, 64'h3fff_ffff_0000_0001},
    '{ACT_LOAD_FIRST,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 64'h0},
    '{ACT_RUN,         3'd7, 3'd7, 32'hffff_ffff, 1'b1, 64'hc000_0000_8000_0000},
    '{ACT_LOAD_SECOND, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 64'h0},
    '{ACT_RUN,         3'd0, 3'd0, 32'h0,         1'b1, 64'h4000_0000_0000_0000},
    '{ACT_NONE,        3'd7, 3'd7, 32'hffff_ffff, 1'b0, 64'h0},
    '{ACT_LOAD_FIRST,  3'd7, 3'd7, 32'hffff_ffff, 1'b0, 64'h0},
    '{ACT_LOAD_SECOND, 3'd7, 3'd7, 32'h0,         1'b0, 64'h0},
    '{ACT_RUN,         3'd0, 3'd0, 32'h0,         1'b1, 64'h4000_0000_0000_0000},
    '{ACT_LOAD_FIRST,  3'd0, 3'd0, 32'hffff_ffff, 1'b0, 64'h0},
    '{ACT_LOAD_SECOND, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 64'h0},
    '{ACT_RUN,         3'd0, 3'd0, 32'h0,         1'b1, 64'hffff_ffff_ffff_ffff},
    '{ACT_LOAD_FIRST,  3'd0, 3'd0, 32'h0,         1'b0, 64'h0},
    '{ACT_RUN,         3'd0, 3'd0, 32'h0,         1'b1, 64'h0}
  };

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_action;
  logic [DIM_W-1:0]  in_elem_row;
  logic [DIM_W-1:0]  in_elem_col;
  logic [31:0]       in_elem_value;
  logic              out_valid;
  logic [DIM_W-1:0]  out_row;
  logic [DIM_W-1:0]  out_col;
  logic [63:0]       out_value;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // local copy of the block's state
  logic [31:0]       first_mat [DEPTH];
  logic [31:0]       second_mat [DEPTH];
  bit                first_seen [DEPTH];
  bit                second_seen [DEPTH];
  logic [CFG_W-1:0]  dim_reg [3];

  product_word_t     expected_products [$];
  int                mismatches = 0;
  int                burst_left = 0;

  integer_matrix_multiply_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int used_dim(input logic [CFG_W-1:0] reg_val);
    if (reg_val == '0) begin
      return 1;
    end else if (reg_val > CFG_W'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(reg_val);
  endfunction

  // product[r][c] = sum_k second[r][k] * first[k][c], column-major order
  function automatic void queue_products();
    int            rows;
    int            inner;
    int            cols;
    longint        sum;
    product_word_t word;
    rows  = used_dim(dim_reg[REG_ROWS]);
    inner = used_dim(dim_reg[REG_INNER]);
    cols  = used_dim(dim_reg[REG_COLS]);
    for (int c = 0; c < cols; c++) begin
      for (int r = 0; r < rows; r++) begin
        sum = 0;
        for (int k = 0; k < inner; k++) begin
          sum += longint'($signed(second_mat[r*MAX_DIM+k])) *
                 longint'($signed(first_mat[k*MAX_DIM+c]));
        end
        word.row   = 3'(r);
        word.col   = 3'(c);
        word.value = sum;
        word.last  = (c == cols - 1) && (r == rows - 1);
        expected_products.push_back(word);
      end
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // present one word, hold until accepted, then update the model
  task automatic send_word(input logic [1:0] act, input logic [2:0] r, input logic [2:0] c,
                           input logic [31:0] v, input logic typed,
                           input logic [63:0] typed_sum);
    product_word_t word;
    start         <= 1'b1;
    in_action     <= act;
    in_elem_row   <= r;
    in_elem_col   <= c;
    in_elem_value <= v;
    do @(posedge clk); while (busy);
    case (act)
      ACT_LOAD_FIRST: begin
        first_mat[{r, c}]  = v;
        first_seen[{r, c}] = 1'b1;
      end
      ACT_LOAD_SECOND: begin
        second_mat[{r, c}]  = v;
        second_seen[{r, c}] = 1'b1;
      end
      ACT_RUN: begin
        if (typed) begin
          word = '{3'd0, 3'd0, typed_sum, 1'b1};
          expected_products.push_back(word);
        end else begin
          queue_products();
        end
      end
      default: ;
    endcase
    // end of a burst: drop start for a random gap
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic apb_access(input logic write, input logic [1:0] reg_idx,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_dim(input logic [1:0] reg_idx, input logic [CFG_W-1:0] val);
    logic [31:0] unused;
    apb_access(1'b1, reg_idx, {(32 - CFG_W)'($urandom), val}, unused);
    dim_reg[reg_idx] = val;
  endtask

  task automatic check_dims();
    logic [31:0] rdata;
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, 2'(i), 32'h0, rdata);
      if (rdata[CFG_W-1:0] !== dim_reg[i]) begin
        $error("register %0d: expected %0d, got %0d", i, dim_reg[i], rdata[CFG_W-1:0]);
        mismatches++;
      end
    end
  endtask

  task automatic wait_idle();
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // load every entry a run will read that has never been written
  task automatic fill_used(inout int count);
    int rows;
    int inner;
    int cols;
    rows  = used_dim(dim_reg[REG_ROWS]);
    inner = used_dim(dim_reg[REG_INNER]);
    cols  = used_dim(dim_reg[REG_COLS]);
    for (int k = 0; k < inner; k++) begin
      for (int c = 0; c < cols; c++) begin
        if (!first_seen[k*MAX_DIM+c]) begin
          send_word(ACT_LOAD_FIRST, 3'(k), 3'(c), pick_value(), 1'b0, '0);
          count++;
        end
      end
      for (int r = 0; r < rows; r++) begin
        if (!second_seen[r*MAX_DIM+k]) begin
          send_word(ACT_LOAD_SECOND, 3'(r), 3'(k), pick_value(), 1'b0, '0);
          count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    product_word_t want;
    if (rst_n && out_valid) begin
      if (expected_products.size() == 0) begin
        $error("unexpected word: row %0d col %0d value %h", out_row, out_col, out_value);
        mismatches++;
      end else begin
        want = expected_products.pop_front();
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          mismatches++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          mismatches++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int               random_count;
    int               phase;
    int               n_items;
    int               rows;
    int               inner;
    int               cols;
    int               pick;
    logic [1:0]       act;
    logic [2:0]       r;
    logic [2:0]       c;
    logic [CFG_W-1:0] dims [3];

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= ACT_LOAD_FIRST;
    in_elem_row   <= '0;
    in_elem_col   <= '0;
    in_elem_value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_mat[i]   = '0;
      second_mat[i]  = '0;
      first_seen[i]  = 1'b0;
      second_seen[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) dim_reg[i] = DIM_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then the directed list at 1x1x1
    check_dims();
    write_dim(REG_ROWS, 4'd1);
    write_dim(REG_INNER, 4'd1);
    write_dim(REG_COLS, 4'd1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i].action, DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].value,
                DIRECTED[i].typed, DIRECTED[i].typed_sum);
    end
    start <= 1'b0;
    wait_idle();

    random_count = 0;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      // extremes first, including zero and above-range dimensions
      case (phase)
        0:       dims = '{4'd0, 4'd0, 4'd0};
        1:       dims = '{4'd15, 4'd15, 4'd15};
        2:       dims = '{4'd8, 4'd1, 4'd8};
        3:       dims = '{4'd1, 4'd9, 4'd1};
        default: begin
          for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 9))
              0:       dims[i] = 4'd0;
              1:       dims[i] = 4'($urandom_range(8, 15));
              2:       dims[i] = 4'($urandom_range(5, 7));
              default: dims[i] = 4'($urandom_range(1, 4));
            endcase
          end
        end
      endcase
      write_dim(REG_ROWS, dims[0]);
      write_dim(REG_INNER, dims[1]);
      write_dim(REG_COLS, dims[2]);
      if (phase < 6) check_dims();
      rows  = used_dim(dim_reg[REG_ROWS]);
      inner = used_dim(dim_reg[REG_INNER]);
      cols  = used_dim(dim_reg[REG_COLS]);

      n_items = $urandom_range(8, 30);
      for (int n = 0; n < n_items; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          act = (pick < 42) ? ACT_LOAD_FIRST : ACT_LOAD_SECOND;
          if ($urandom_range(0, 4) == 0) begin
            r = 3'($urandom);
            c = 3'($urandom);
          end else if (act == ACT_LOAD_FIRST) begin
            r = 3'($urandom_range(0, inner - 1));
            c = 3'($urandom_range(0, cols - 1));
          end else begin
            r = 3'($urandom_range(0, rows - 1));
            c = 3'($urandom_range(0, inner - 1));
          end
          send_word(act, r, c, pick_value(), 1'b0, '0);
          random_count++;
        end else if (pick < 93) begin
          fill_used(random_count);
          send_word(ACT_RUN, 3'($urandom), 3'($urandom), $urandom, 1'b0, '0);
          random_count++;
        end else begin
          send_word(ACT_NONE, 3'($urandom), 3'($urandom), $urandom, 1'b0, '0);
        end
      end
      fill_used(random_count);
      send_word(ACT_RUN, 3'($urandom), 3'($urandom), $urandom, 1'b0, '0);
      random_count++;
      start <= 1'b0;
      // hold off until every product of this phase is back
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/imm_pkg.sv
rtl/imm_ram.sv
rtl/imm_front.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply_core.sv
rtl/imm_checker.sv
tb/integer_matrix_multiply_core_test.sv
